@@ sv/buddy_page_allocator_unit_defines.svh @@
// Assertion macros shared by the buddy page allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Condition that must hold at every rising clock edge outside reset.
`define BPA_ASSERT(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (rst) \
  (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) lbl: assert property ( \
  @(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bpa_pkg.sv @@
// Package with the shared constants and codes of the buddy page allocator.
package bpa_pkg;
  localparam int PAGES_LOG2_DEF = 10;
  localparam int MAX_ORDER_DEF  = 10;
  // Internal order width, enough for orders up to 20.
  localparam int OW = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_BAD_ORDER = 3'd4
  } status_t;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_LOG2 = 1'b1;
endpackage

@@ sv/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/buddy_page_allocator_unit.sv @@
// Buddy page allocator: sequencer over free-mark, page-flag and order memories.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready cmd req_order page_number | to block
//  out     | out_valid out_ready status result_page      | from block
//          | is_allocated block_order free_pages         |
//  cfg     | cfg_we cfg_index cfg_wdata                  | to block
//
// Allocate: a memory read and a check for each free mark examined, a split
// step per order above the request, a step per page to mark the block's pages,
// then the result. Free: a page-flag read and check, a step per page to clear
// the pages, a read and a check per merge step, then the result. Query: a
// page-flag read and check. The single free-mark port paces the search.
// After reset and after each region_pages_log2 write a clearing pass over all
// free-mark entries runs before the first input transaction is taken.
// A finished result waits in the output register; the next input is taken
// meanwhile and only its own result waits for out_ready.
`include "buddy_page_allocator_unit_defines.svh"
module buddy_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int PAGES_LOG2 = PAGES_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [3:0]  req_order,
  input  logic [51:0] page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [51:0] result_page,
  output logic        is_allocated,
  output logic [3:0]  block_order,
  output logic [10:0] free_pages,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [51:0] cfg_wdata
);
  localparam int PW  = PAGES_LOG2;
  localparam int CW  = PAGES_LOG2 + 1;
  localparam int NAW = PAGES_LOG2 + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALLOC_RD, S_ALLOC_CHK, S_SPLIT, S_FILL, S_LOOK,
    S_FREE_CHK, S_UNFILL, S_MERGE_RD, S_MERGE_CHK, S_DONE
  } state_t;

  state_t        state;
  logic [51:0]   base;
  logic [3:0]    log2_reg;
  logic [1:0]    cmd_r;
  logic [OW-1:0] ord;
  logic [OW-1:0] o;
  logic [CW-1:0] b;
  logic [PW-1:0] p;
  logic [CW-1:0] i;
  logic [CW-1:0] clr;
  logic [CW-1:0] cnt;
  status_t       res_status;
  logic [51:0]   res_page;
  logic          res_alloc;
  logic [OW-1:0] res_order;

  logic [OW-1:0]  l;
  logic [OW-1:0]  top;
  logic [51:0]    off;
  logic           oob;
  logic [CW-1:0]  lim_o;
  logic [CW-1:0]  lim_l;
  logic [NAW-1:0] init_lo;

  logic           fm_we;
  logic [NAW-1:0] fm_waddr;
  logic           fm_wdata;
  logic [NAW-1:0] fm_raddr;
  logic           fm_rdata;
  logic           pa_we;
  logic [PW-1:0]  pa_waddr;
  logic           pa_wdata;
  logic           pa_rdata;
  logic           so_we;
  logic [OW-1:0]  so_rdata;

  function automatic logic [OW-1:0] eff_f(input logic [3:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return (w > OW'(PAGES_LOG2)) ? OW'(PAGES_LOG2) : w;
  endfunction

  function automatic logic [NAW-1:0] node_f(input logic [OW-1:0] lv,
                                            input logic [OW-1:0] ov,
                                            input logic [CW-1:0] bv);
    return NAW'((NAW'(1) << (lv - ov)) + NAW'(bv));
  endfunction

  // Region geometry and range check of the incoming page.
  always_comb begin
    l       = eff_f(log2_reg);
    top     = (l > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : l;
    off     = page_number - base;
    oob     = (page_number < base) || (off >= (52'(1) << l));
    lim_o   = CW'(1) << (l - o);
    lim_l   = CW'(1) << l;
    init_lo = NAW'(1) << (l - top);
  end

  assign in_ready = (state == S_IDLE);

  // Memory port control per sequencer step.
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = node_f(l, o, b);
    fm_wdata = 1'b0;
    fm_raddr = node_f(l, o, b);
    pa_we    = 1'b0;
    pa_waddr = PW'(CW'(p) + i);
    pa_wdata = 1'b0;
    so_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = NAW'(clr);
        fm_wdata = (NAW'(clr) >= init_lo) && ({1'b0, NAW'(clr)} < {init_lo, 1'b0});
        pa_we    = !clr[CW-1];
        pa_waddr = clr[PW-1:0];
      end
      S_ALLOC_CHK: begin
        fm_we = fm_rdata;
      end
      S_SPLIT: begin
        fm_we    = (o > ord);
        fm_waddr = node_f(l, o - OW'(1), CW'(b << 1) + CW'(1));
        fm_wdata = 1'b1;
      end
      S_FILL: begin
        pa_we    = 1'b1;
        pa_wdata = 1'b1;
        so_we    = 1'b1;
      end
      S_UNFILL: begin
        pa_we = 1'b1;
      end
      S_MERGE_RD: begin
        fm_raddr = node_f(l, o, b ^ CW'(1));
        fm_we    = !(o < top);
        fm_wdata = 1'b1;
      end
      S_MERGE_CHK: begin
        fm_we    = 1'b1;
        fm_waddr = fm_rdata ? node_f(l, o, b ^ CW'(1)) : node_f(l, o, b);
        fm_wdata = !fm_rdata;
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(.WIDTH(1), .DEPTH(2 ** NAW)) u_free_marks (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );

  bpa_ram #(.WIDTH(1), .DEPTH(2 ** PW)) u_page_alloc (
    .clk(clk), .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
    .raddr(p), .rdata(pa_rdata)
  );

  bpa_ram #(.WIDTH(OW), .DEPTH(2 ** PW)) u_block_order (
    .clk(clk), .we(so_we), .waddr(pa_waddr), .wdata(ord),
    .raddr(p), .rdata(so_rdata)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      base      <= '0;
      log2_reg  <= 4'd10;
      cnt       <= CW'(1) << eff_f(4'd10);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == REG_LOG2) begin
        // A region size write restarts the clearing pass.
        log2_reg <= cfg_wdata[3:0];
        cnt      <= CW'(1) << eff_f(cfg_wdata[3:0]);
        clr      <= '0;
        state    <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            clr <= clr + CW'(1);
            if (clr == {CW{1'b1}}) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              cmd_r      <= cmd;
              res_status <= ST_OK;
              res_page   <= '0;
              res_alloc  <= 1'b0;
              res_order  <= '0;
              ord        <= OW'(req_order);
              o          <= OW'(req_order);
              b          <= '0;
              p          <= off[PW-1:0];
              case (cmd)
                CMD_ALLOC: begin
                  if (OW'(req_order) > OW'(MAX_ORDER)) begin
                    res_status <= ST_BAD_ORDER;
                    state      <= S_DONE;
                  end else if (OW'(req_order) > top) begin
                    res_status <= ST_NO_SPACE;
                    state      <= S_DONE;
                  end else begin
                    state <= S_ALLOC_RD;
                  end
                end
                CMD_FREE, CMD_QUERY: begin
                  if (oob) begin
                    res_status <= ST_RANGE;
                    state      <= S_DONE;
                  end else begin
                    state <= S_LOOK;
                  end
                end
                default: begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end
              endcase
            end
          end
          S_ALLOC_RD: begin
            state <= S_ALLOC_CHK;
          end
          S_ALLOC_CHK: begin
            // Take the first free mark; otherwise step to the next block or order.
            if (fm_rdata) begin
              state <= S_SPLIT;
            end else if (b + CW'(1) == lim_o) begin
              if (o == top) begin
                res_status <= ST_NO_SPACE;
                state      <= S_DONE;
              end else begin
                o     <= o + OW'(1);
                b     <= '0;
                state <= S_ALLOC_RD;
              end
            end else begin
              b     <= b + CW'(1);
              state <= S_ALLOC_RD;
            end
          end
          S_SPLIT: begin
            // Keep the lower half; the upper buddy was marked free above.
            if (o > ord) begin
              o <= o - OW'(1);
              b <= CW'(b << 1);
            end else begin
              p     <= PW'(b << ord);
              i     <= '0;
              state <= S_FILL;
            end
          end
          S_FILL: begin
            i <= i + CW'(1);
            if (i == (CW'(1) << ord) - CW'(1)) begin
              cnt       <= cnt - (CW'(1) << ord);
              res_page  <= base + 52'(p);
              res_order <= ord;
              state     <= S_DONE;
            end
          end
          S_LOOK: begin
            state <= S_FREE_CHK;
          end
          S_FREE_CHK: begin
            if (cmd_r == CMD_QUERY) begin
              res_alloc <= pa_rdata;
              state     <= S_DONE;
            end else if (!pa_rdata || so_rdata > top ||
                         (p & PW'((CW'(1) << so_rdata) - CW'(1))) != '0) begin
              res_status <= ST_NOT_ALLOC;
              state      <= S_DONE;
            end else begin
              o     <= so_rdata;
              i     <= '0;
              state <= S_UNFILL;
            end
          end
          S_UNFILL: begin
            i <= i + CW'(1);
            if (i == (CW'(1) << o) - CW'(1)) begin
              cnt       <= cnt + (CW'(1) << o);
              res_order <= o;
              b         <= CW'(p) >> o;
              state     <= S_MERGE_RD;
            end
          end
          S_MERGE_RD: begin
            // At the top order the block's own mark is set here.
            state <= (o < top) ? S_MERGE_CHK : S_DONE;
          end
          S_MERGE_CHK: begin
            if (fm_rdata) begin
              o     <= o + OW'(1);
              b     <= b >> 1;
              state <= S_MERGE_RD;
            end else begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid    <= 1'b1;
              status       <= res_status;
              result_page  <= res_page;
              is_allocated <= res_alloc;
              block_order  <= 4'(res_order);
              free_pages   <= 11'(cnt);
              state        <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
      // Region base write.
      if (cfg_we && cfg_index == REG_BASE) begin
        base <= cfg_wdata;
      end
    end
  end

  `BPA_ASSERT(a_cnt_bound, cnt <= lim_l, "free page count exceeds region size")
  `BPA_ASSERT(a_fill_bound, !(state == S_FILL) || i < (CW'(1) << ord), "fill overran block")
  `BPA_ASSERT(a_merge_top, !(state == S_MERGE_RD) || o <= top, "merge passed top order")
  `BPA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready && !cfg_we, state != S_IDLE, "item lost")
endmodule

@@ sim/bpa_checker.sv @@
// Checker for the buddy page allocator: predicts each result and compares it.
module bpa_checker
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [3:0]  req_order,
  input  logic [51:0] page_number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [51:0] result_page,
  input  logic        is_allocated,
  input  logic [3:0]  block_order,
  input  logic [10:0] free_pages,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [51:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPG = 1 << PAGES_LOG2_DEF;
  localparam int NND = 2 << PAGES_LOG2_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] page;
    logic        alloc;
    logic [3:0]  order;
    logic [10:0] free_cnt;
  } alloc_result_t;

  logic [51:0] base_page;
  logic [3:0]  size_log2;
  logic        free_mark [NND];
  logic        page_used [NPG];
  logic [3:0]  page_order [NPG];
  int          free_count;
  alloc_result_t expected_results[$];

  function automatic int span_log2();
    return (size_log2 > PAGES_LOG2_DEF) ? PAGES_LOG2_DEF : int'(size_log2);
  endfunction

  function automatic int top_ord();
    return (span_log2() > MAX_ORDER_DEF) ? MAX_ORDER_DEF : span_log2();
  endfunction

  function automatic int node_idx(int o, int b);
    return ((1 << (span_log2() - o)) + b) & (NND - 1);
  endfunction

  // Marks the whole region free, as after reset or a size write.
  task automatic init_region();
    int top;
    top = top_ord();
    for (int i = 0; i < NND; i++) free_mark[i] = 1'b0;
    for (int i = 0; i < NPG; i++) page_used[i] = 1'b0;
    for (int b = 0; b < (1 << (span_log2() - top)); b++) free_mark[node_idx(top, b)] = 1'b1;
    free_count = 1 << span_log2();
  endtask

  // Applies one request to the model state and returns its result.
  task automatic apply_request(input logic [1:0] c, input logic [3:0] ord,
                               input logic [51:0] pg, output alloc_result_t r);
    int l, top, o, b, start, p, bo;
    bit found;
    logic [51:0] off;
    l = span_log2();
    top = top_ord();
    r = '0;
    if (c == CMD_ALLOC) begin
      if (ord > MAX_ORDER_DEF) begin
        r.status = ST_BAD_ORDER;
      end else begin
        found = 0;
        for (o = ord; o <= top; o++) begin
          for (b = 0; b < (1 << (l - o)); b++) begin
            if (free_mark[node_idx(o, b)]) begin
              found = 1;
              break;
            end
          end
          if (found) break;
        end
        if (!found) begin
          r.status = ST_NO_SPACE;
        end else begin
          free_mark[node_idx(o, b)] = 1'b0;
          while (o > ord) begin
            o--;
            b = b << 1;
            free_mark[node_idx(o, b + 1)] = 1'b1;
          end
          start = b << ord;
          for (int i = 0; i < (1 << ord); i++) begin
            page_used[(start + i) & (NPG - 1)] = 1'b1;
            page_order[(start + i) & (NPG - 1)] = ord;
          end
          free_count -= 1 << ord;
          r.page = base_page + 52'(start);
          r.order = ord;
        end
      end
    end else if (c == CMD_FREE || c == CMD_QUERY) begin
      off = pg - base_page;
      if (pg < base_page || off >= (52'd1 << l)) begin
        r.status = ST_RANGE;
      end else if (c == CMD_QUERY) begin
        r.alloc = page_used[int'(off) & (NPG - 1)];
      end else begin
        p = int'(off);
        bo = page_used[p] ? int'(page_order[p]) : 0;
        if (!page_used[p] || bo > top || (p & ((1 << bo) - 1)) != 0) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          for (int i = 0; i < (1 << bo); i++) page_used[(p + i) & (NPG - 1)] = 1'b0;
          free_count += 1 << bo;
          r.order = 4'(bo);
          o = bo;
          b = p >> bo;
          while (o < top && free_mark[node_idx(o, b ^ 1)]) begin
            free_mark[node_idx(o, b ^ 1)] = 1'b0;
            o++;
            b = b >> 1;
          end
          free_mark[node_idx(o, b)] = 1'b1;
        end
      end
    end else begin
      r.status = ST_RANGE;
    end
    r.free_cnt = 11'(free_count);
  endtask

  // Watches the three channels at each rising edge.
  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (rst) begin
      base_page = '0;
      size_log2 = 4'd10;
      init_region();
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, result_page, is_allocated, block_order, free_pages};
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got.status);
            errors++;
          end
          if (got.page !== exp_r.page) begin
            $error("result_page expected %0h actual %0h", exp_r.page, got.page);
            errors++;
          end
          if (got.alloc !== exp_r.alloc) begin
            $error("is_allocated expected %0d actual %0d", exp_r.alloc, got.alloc);
            errors++;
          end
          if (got.order !== exp_r.order) begin
            $error("block_order expected %0d actual %0d", exp_r.order, got.order);
            errors++;
          end
          if (got.free_cnt !== exp_r.free_cnt) begin
            $error("free_pages expected %0d actual %0d", exp_r.free_cnt, got.free_cnt);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(cmd, req_order, page_number, exp_r);
        expected_results.push_back(exp_r);
      end
      if (cfg_we) begin
        if (cfg_index == REG_BASE) begin
          base_page = cfg_wdata;
        end else begin
          size_log2 = cfg_wdata[3:0];
          init_region();
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ sim/tb.sv @@
// Testbench top for the buddy page allocator: stimulus, idling and verdict.
module tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [3:0]  req_order = '0;
  logic [51:0] page_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [51:0] result_page;
  logic        is_allocated;
  logic [3:0]  block_order;
  logic [10:0] free_pages;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_BASE;
  logic [51:0] cfg_wdata = '0;
  int          errors;
  int          pending;

  int          send_gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  int          quiet_cycles = 0;
  logic [51:0] cur_base = '0;
  int          cur_log2 = 10;
  logic [1:0]  sent_cmds[$];
  logic [51:0] live_blocks[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  buddy_page_allocator_unit dut (.*);

  bpa_checker chk (.*);

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready = 1'b0;
      repeat (400) @(negedge clk);
      hold_done = 1;
    end
    out_ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // Track live allocated blocks so frees can target them.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && sent_cmds.size() > 0) begin
      if (sent_cmds.pop_front() == CMD_ALLOC && status == ST_OK)
        live_blocks.push_back(result_page);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[buddy_page_allocator_unit] ERROR");
      $finish;
    end
  end

  task automatic send(input logic [1:0] c, input logic [3:0] ord, input logic [51:0] pg);
    while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk);
    in_valid = 1'b1;
    cmd = c;
    req_order = ord;
    page_number = pg;
    do @(posedge clk); while (!in_ready);
    sent_cmds.push_back(c);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [51:0] val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_BASE) cur_base = val;
    else begin
      cur_log2 = (val[3:0] > 10) ? 10 : int'(val[3:0]);
      live_blocks.delete();
    end
  endtask

  function automatic logic [51:0] rand52();
    return {20'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [51:0] region_page();
    return cur_base + 52'($urandom_range(0, (1 << cur_log2) - 1));
  endfunction

  // Mostly small-order traffic with frees of live blocks; some noise.
  task automatic random_traffic(input int n);
    int k, pick;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        send(CMD_ALLOC, ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3)), rand52());
      end else if (k < 80) begin
        if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          send(CMD_FREE, 4'($urandom), live_blocks[pick]);
          live_blocks.delete(pick);
        end else begin
          send(CMD_FREE, 4'($urandom), region_page());
        end
      end else if (k < 95) begin
        send(CMD_QUERY, 4'($urandom), region_page());
      end else if (k < 97) begin
        send(2'd3, 4'($urandom), rand52());
      end else begin
        send(2'($urandom_range(1, 2)), 4'($urandom), rand52());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: order extremes, every command and the error cases.
    send(CMD_ALLOC, 4'd0, '0);
    send(CMD_QUERY, 4'd0, 52'd0);
    send(CMD_QUERY, 4'd0, 52'd1);
    send(CMD_FREE, 4'd0, 52'd1);
    send(CMD_FREE, 4'd0, 52'd0);
    send(CMD_FREE, 4'd0, 52'd0);
    send(CMD_ALLOC, 4'd10, '0);
    send(CMD_ALLOC, 4'd0, '0);
    send(CMD_ALLOC, 4'd11, '0);
    send(CMD_ALLOC, 4'd15, '0);
    send(CMD_QUERY, 4'd15, 52'd1023);
    send(CMD_QUERY, 4'd0, 52'd1024);
    send(CMD_FREE, 4'd0, '1);
    send(2'd3, 4'd15, '1);
    send(CMD_FREE, 4'd0, 52'd0);
    send(CMD_ALLOC, 4'd2, '0);
    send(CMD_ALLOC, 4'd1, '0);
    send(CMD_FREE, 4'd0, 52'd1);
    send(CMD_FREE, 4'd0, 52'd4);
    send(CMD_FREE, 4'd0, 52'd0);
    send(CMD_QUERY, 4'd0, 52'd4);

    // Phases over several region settings and idling modes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LOG2, 52'd10);
        end
        1: begin
          write_reg(REG_BASE, 52'hF_FFFF_FFFF_FFFD);
          write_reg(REG_LOG2, 52'd3);
        end
        2: begin
          write_reg(REG_BASE, rand52());
          write_reg(REG_LOG2, 52'd0);
        end
        3: begin
          write_reg(REG_BASE, 52'd0);
          write_reg(REG_LOG2, 52'hF);
        end
        4: begin
          write_reg(REG_BASE, rand52());
          write_reg(REG_LOG2, 52'd5);
        end
        default: begin
          write_reg(REG_BASE, 52'h5_5555_AAAA_0000);
          write_reg(REG_LOG2, 52'd7);
        end
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 51; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 51; end
        default: begin send_gap_pct = 17; stall_pct = 17; end
      endcase
      if (ph == 3) hold_req = 1;
      random_traffic(310);
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("[buddy_page_allocator_unit] OK");
    else
      $display("[buddy_page_allocator_unit] ERROR");
    $finish;
  end
endmodule
